[src/gbe_pkg.sv]
`default_nettype none

package gbe_pkg;

    localparam int CNT_W  = 13;
    localparam int POS_W  = 12;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;
    localparam int ACT_W  = 4;

    // longest UTF-8 character in bytes
    localparam int UTF_MAX_LEN = 4;

    localparam logic [ACT_W-1:0] ACT_INSERT      = 4'd0;
    localparam logic [ACT_W-1:0] ACT_DEL_BEFORE  = 4'd1;
    localparam logic [ACT_W-1:0] ACT_DEL_AFTER   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_LEFT_BYTES  = 4'd3;
    localparam logic [ACT_W-1:0] ACT_RIGHT_BYTES = 4'd4;
    localparam logic [ACT_W-1:0] ACT_LEFT_CHARS  = 4'd5;
    localparam logic [ACT_W-1:0] ACT_RIGHT_CHARS = 4'd6;
    localparam logic [ACT_W-1:0] ACT_DEL_CHAR_BF = 4'd7;
    localparam logic [ACT_W-1:0] ACT_DEL_CHAR_AF = 4'd8;
    localparam logic [ACT_W-1:0] ACT_READ        = 4'd9;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_EDGE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] insert_byte;
        logic [CNT_W-1:0]  step_count;
        logic [POS_W-1:0]  read_position;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0]  done_count;
        logic [CNT_W-1:0]  cursor_pos;
        logic [CNT_W-1:0]  text_len;
        logic [BYTE_W-1:0] read_byte;
        logic [STAT_W-1:0] status;
    } t_result;

    function automatic logic is_cont(input logic [BYTE_W-1:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // character length from its lead byte, zero for a byte that cannot lead
    function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [2:0] len;
        if (!b[7]) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

[src/gbe_ram.sv]
`default_nettype none

module gbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/gap_buffer_edit_engine.sv]
`default_nettype none
// Insert, byte deletes, unknown actions and reads past the text end: the result strobe is registered and
// comes in the cycle after start, busy stays low. Read: one RAM read, then the registered result strobe.
// Byte moves: one byte per cycle is copied through the RAM ports in S_COPY.
// Character steps: S_STEP, then S_SCAN_RD and S_SCAN_CHK per byte scanned; moves then copy the character in S_COPY.
// Results cannot be stalled; start is taken whenever busy is low.
// Reset (synchronous): empty text, cursor 0; store contents stay undefined, no clearing pass.

module gap_buffer_edit_engine #(
    parameter int CAPACITY = 4096
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire gbe_pkg::t_item  i_item,
    output logic                 o_strobe,
    output gbe_pkg::t_result     o_result
);

    import gbe_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = (PW > CNT_W) ? PW : CNT_W;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_STEP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_COPY
    } t_state;

    t_state              r_state, n_state;
    logic [PW-1:0]       r_gs, n_gs;
    logic [PW-1:0]       r_ge, n_ge;
    logic [PW-1:0]       r_tl, n_tl;
    logic [ACT_W-1:0]    r_act, n_act;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_done, n_done;
    logic [CW-1:0]       r_left, n_left;
    logic [2:0]          r_k, n_k;
    logic [2:0]          r_len, n_len;
    logic [STAT_W-1:0]   r_stat, n_stat;
    logic                r_wp, n_wp;
    logic [AW-1:0]       r_wa, n_wa;
    logic                r_strobe, n_strobe;
    t_result             r_result, n_result;

    logic                ram_we;
    logic [AW-1:0]       ram_wa;
    logic [BYTE_W-1:0]   ram_wd;
    logic [AW-1:0]       ram_ra;
    logic [BYTE_W-1:0]   ram_rd;

    logic                fin;
    logic [STAT_W-1:0]   fin_status;
    logic [BYTE_W-1:0]   fin_byte;
    logic                unit_ok;
    logic [2:0]          unit_len;

    logic                dir_before;
    logic                is_chars;
    logic                is_del;
    logic [CW-1:0]       cnt_ext;
    logic [CW-1:0]       avail_bf;
    logic [CW-1:0]       avail_af;
    logic [CW-1:0]       take_bf;
    logic [CW-1:0]       take_af;
    logic [CW-1:0]       pos_ext;
    logic [CW-1:0]       rd_idx;
    logic [PW-1:0]       free_sp;
    logic [2:0]          lead_l;

    gbe_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(ram_ra),
        .o_rdata(ram_rd)
    );

    assign dir_before = (r_act == ACT_DEL_BEFORE) || (r_act == ACT_LEFT_BYTES) ||
                        (r_act == ACT_LEFT_CHARS) || (r_act == ACT_DEL_CHAR_BF);
    assign is_chars   = (r_act >= ACT_LEFT_CHARS);
    assign is_del     = (r_act == ACT_DEL_BEFORE) || (r_act == ACT_DEL_AFTER) ||
                        (r_act == ACT_DEL_CHAR_BF) || (r_act == ACT_DEL_CHAR_AF);

    assign free_sp  = r_ge - r_gs;
    assign cnt_ext  = CW'(i_item.step_count);
    assign avail_bf = CW'(r_gs);
    assign avail_af = CW'(CAP_P - r_ge);
    assign take_bf  = (cnt_ext > avail_bf) ? avail_bf : cnt_ext;
    assign take_af  = (cnt_ext > avail_af) ? avail_af : cnt_ext;
    assign pos_ext  = CW'(i_item.read_position);
    assign rd_idx   = (pos_ext < CW'(r_gs)) ? pos_ext : pos_ext + CW'(free_sp);
    assign lead_l   = lead_len(ram_rd);

    always_comb begin
        n_state    = r_state;
        n_gs       = r_gs;
        n_ge       = r_ge;
        n_tl       = r_tl;
        n_act      = r_act;
        n_count    = r_count;
        n_done     = r_done;
        n_left     = r_left;
        n_k        = r_k;
        n_len      = r_len;
        n_stat     = r_stat;
        n_wp       = r_wp;
        n_wa       = r_wa;
        n_result   = r_result;
        ram_we     = 1'b0;
        ram_wa     = r_wa;
        ram_wd     = ram_rd;
        ram_ra     = '0;
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_byte   = '0;
        unit_ok    = 1'b0;
        unit_len   = r_len;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_act   = i_item.action;
                    n_count = i_item.step_count;
                    n_done  = '0;
                    unique case (i_item.action) inside
                        ACT_INSERT: begin
                            fin = 1'b1;
                            if (free_sp <= PW'(1)) begin
                                fin_status = ST_FULL;
                            end else begin
                                ram_we = 1'b1;
                                ram_wa = AW'(r_gs);
                                ram_wd = i_item.insert_byte;
                                n_gs   = r_gs + PW'(1);
                                n_tl   = r_tl + PW'(1);
                                n_done = CNT_W'(1);
                            end
                        end
                        ACT_DEL_BEFORE: begin
                            fin        = 1'b1;
                            n_gs       = r_gs - PW'(take_bf);
                            n_tl       = r_tl - PW'(take_bf);
                            n_done     = CNT_W'(take_bf);
                            fin_status = (cnt_ext > avail_bf) ? ST_EDGE : ST_OK;
                        end
                        ACT_DEL_AFTER: begin
                            fin        = 1'b1;
                            n_ge       = r_ge + PW'(take_af);
                            n_tl       = r_tl - PW'(take_af);
                            n_done     = CNT_W'(take_af);
                            fin_status = (cnt_ext > avail_af) ? ST_EDGE : ST_OK;
                        end
                        ACT_LEFT_BYTES: begin
                            n_left  = take_bf;
                            n_done  = CNT_W'(take_bf);
                            n_stat  = (cnt_ext > avail_bf) ? ST_EDGE : ST_OK;
                            n_wp    = 1'b0;
                            n_state = S_COPY;
                        end
                        ACT_RIGHT_BYTES: begin
                            n_left  = take_af;
                            n_done  = CNT_W'(take_af);
                            n_stat  = (cnt_ext > avail_af) ? ST_EDGE : ST_OK;
                            n_wp    = 1'b0;
                            n_state = S_COPY;
                        end
                        ACT_LEFT_CHARS, ACT_RIGHT_CHARS,
                        ACT_DEL_CHAR_BF, ACT_DEL_CHAR_AF: begin
                            n_state = S_STEP;
                        end
                        ACT_READ: begin
                            if (pos_ext < CW'(r_tl)) begin
                                ram_ra  = AW'(rd_idx);
                                n_state = S_RD_WAIT;
                            end else begin
                                fin        = 1'b1;
                                fin_status = ST_EDGE;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_RD_WAIT: begin
                fin      = 1'b1;
                n_done   = CNT_W'(1);
                fin_byte = ram_rd;
            end

            S_STEP: begin
                if (r_done == r_count) begin
                    fin = 1'b1;
                end else if (dir_before ? (r_gs == '0) : (r_ge == CAP_P)) begin
                    fin        = 1'b1;
                    fin_status = ST_EDGE;
                end else begin
                    n_k     = '0;
                    n_state = S_SCAN_RD;
                end
            end

            S_SCAN_RD: begin
                if (dir_before) begin
                    if (r_k == 3'(UTF_MAX_LEN) || PW'(r_k) >= r_gs) begin
                        fin        = 1'b1;
                        fin_status = ST_INVALID;
                    end else begin
                        ram_ra  = AW'(r_gs - PW'(1) - PW'(r_k));
                        n_state = S_SCAN_CHK;
                    end
                end else begin
                    ram_ra  = AW'(r_ge + PW'(r_k));
                    n_state = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK: begin
                if (dir_before) begin
                    // walk back over continuation bytes until the lead shows up
                    if (is_cont(ram_rd)) begin
                        n_k     = r_k + 3'd1;
                        n_state = S_SCAN_RD;
                    end else if (lead_l == r_k + 3'd1) begin
                        unit_ok  = 1'b1;
                        unit_len = r_k + 3'd1;
                    end else begin
                        fin        = 1'b1;
                        fin_status = ST_INVALID;
                    end
                end else if (r_k == '0) begin
                    if (lead_l == '0 || PW'(lead_l) > CAP_P - r_ge) begin
                        fin        = 1'b1;
                        fin_status = ST_INVALID;
                    end else if (lead_l == 3'd1) begin
                        unit_ok  = 1'b1;
                        unit_len = lead_l;
                    end else begin
                        n_len   = lead_l;
                        n_k     = 3'd1;
                        n_state = S_SCAN_RD;
                    end
                end else if (!is_cont(ram_rd)) begin
                    fin        = 1'b1;
                    fin_status = ST_INVALID;
                end else if (r_k + 3'd1 == r_len) begin
                    unit_ok  = 1'b1;
                    unit_len = r_len;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = S_SCAN_RD;
                end
            end

            S_COPY: begin
                // write back the byte read last cycle
                if (r_wp) begin
                    ram_we = 1'b1;
                    ram_wa = r_wa;
                    ram_wd = ram_rd;
                end
                if (r_left != '0) begin
                    if (dir_before) begin
                        ram_ra = AW'(r_gs - PW'(1));
                        n_wa   = AW'(r_ge - PW'(1));
                        n_gs   = r_gs - PW'(1);
                        n_ge   = r_ge - PW'(1);
                    end else begin
                        ram_ra = AW'(r_ge);
                        n_wa   = AW'(r_gs);
                        n_gs   = r_gs + PW'(1);
                        n_ge   = r_ge + PW'(1);
                    end
                    n_wp   = 1'b1;
                    n_left = r_left - CW'(1);
                end else begin
                    n_wp = 1'b0;
                    if (is_chars) begin
                        n_state = S_STEP;
                    end else begin
                        fin        = 1'b1;
                        fin_status = r_stat;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (unit_ok) begin
            n_done = r_done + CNT_W'(1);
            if (is_del) begin
                if (dir_before) begin
                    n_gs = r_gs - PW'(unit_len);
                end else begin
                    n_ge = r_ge + PW'(unit_len);
                end
                n_tl    = r_tl - PW'(unit_len);
                n_state = S_STEP;
            end else begin
                n_left  = CW'(unit_len);
                n_wp    = 1'b0;
                n_state = S_COPY;
            end
        end

        n_strobe = fin;
        if (fin) begin
            n_state             = S_IDLE;
            n_result.done_count = n_done;
            n_result.cursor_pos = CNT_W'(n_gs);
            n_result.text_len   = CNT_W'(n_tl);
            n_result.read_byte  = fin_byte;
            n_result.status     = fin_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_count  <= n_count;
        r_done   <= n_done;
        r_left   <= n_left;
        r_k      <= n_k;
        r_len    <= n_len;
        r_stat   <= n_stat;
        r_wa     <= n_wa;
        r_result <= n_result;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gs     <= '0;
            r_ge     <= CAP_P;
            r_tl     <= '0;
            r_wp     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_gs     <= n_gs;
            r_ge     <= n_ge;
            r_tl     <= n_tl;
            r_wp     <= n_wp;
            r_strobe <= n_strobe;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

[src/gbe_checker.sv]
`default_nettype none

module gbe_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire gbe_pkg::t_item   i_item,
    input wire logic             o_strobe,
    input wire gbe_pkg::t_result o_result
);

    import gbe_pkg::*;

    // an accepted beat either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("accepted beat neither answered nor kept busy");

    // an insert answers on the next cycle and leaves the block free
    a_insert_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == ACT_INSERT) |=> (o_strobe && !busy))
        else $error("insert did not answer on the next cycle");

    // busy only rises after an accepted beat
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    // a long operation ends with its result beat
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy dropped without result");

    // a refused insert reports no bytes done and a zero read byte
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_FULL) |->
            (o_result.done_count == '0 && o_result.read_byte == '0))
        else $error("full status with nonzero result");

endmodule

bind gap_buffer_edit_engine gbe_checker u_gbe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_item  (i_item),
    .o_strobe(o_strobe),
    .o_result(o_result)
);

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;
    import gbe_pkg::*;

    localparam int CAP = 4096;
    localparam int REPORT_MAX = 10;
    localparam logic [ACT_W-1:0] ACT_UNKNOWN_LO = ACT_READ + 1'b1;
    localparam logic [ACT_W-1:0] ACT_UNKNOWN_HI = '1;
    localparam logic [CNT_W-1:0] COUNT_ALL = CNT_W'(CAP);

    // Shadow copy of the text store; predicts one result per accepted edit.
    class gap_buffer_shadow;
        logic [BYTE_W-1:0] store [CAP];
        int unsigned gap_start;
        int unsigned gap_end;
        int unsigned text_length;
        int unsigned free_space;
        t_result edit_outcomes [$];
        int unsigned mismatches;
        int unsigned results_checked;
        int unsigned longest_text;
        int unsigned status_tally [4];

        function new();
            gap_start = 0;
            gap_end = CAP;
            text_length = 0;
            free_space = CAP;
            mismatches = 0;
            results_checked = 0;
            longest_text = 0;
            foreach (store[i]) store[i] = '0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function bit is_trail(logic [BYTE_W-1:0] b);
            return b[7:6] == 2'b10;
        endfunction

        function int unsigned char_width(logic [BYTE_W-1:0] b);
            if (!b[7]) return 1;
            if (b[7:5] == 3'b110) return 2;
            if (b[7:4] == 4'b1110) return 3;
            if (b[7:3] == 5'b11110) return 4;
            return 0;
        endfunction

        function int unsigned width_after();
            int unsigned n;
            int unsigned k;
            n = char_width(store[gap_end]);
            if (n == 0 || n > CAP - gap_end) return 0;
            for (k = 1; k < n; k++) begin
                if (!is_trail(store[gap_end + k])) return 0;
            end
            return n;
        endfunction

        // Scan back over at most four bytes for the lead of the previous character.
        function int unsigned width_before();
            int unsigned i;
            logic [BYTE_W-1:0] b;
            for (i = 0; i < UTF_MAX_LEN; i++) begin
                if (i >= gap_start) return 0;
                b = store[gap_start - 1 - i];
                if (!is_trail(b)) return (char_width(b) == i + 1) ? i + 1 : 0;
            end
            return 0;
        endfunction

        function int unsigned step_run(logic [ACT_W-1:0] act, int unsigned count,
                                       output logic [STAT_W-1:0] st);
            int unsigned done;
            int unsigned n;
            int unsigned k;
            bit back;
            bit by_char;
            bit erase;
            back = act == ACT_DEL_BEFORE || act == ACT_LEFT_BYTES ||
                   act == ACT_LEFT_CHARS || act == ACT_DEL_CHAR_BF;
            by_char = act >= ACT_LEFT_CHARS;
            erase = act == ACT_DEL_BEFORE || act == ACT_DEL_AFTER ||
                    act == ACT_DEL_CHAR_BF || act == ACT_DEL_CHAR_AF;
            done = 0;
            st = ST_OK;
            while (done < count) begin
                n = 1;
                if (back ? (gap_start == 0) : (gap_end >= CAP)) begin
                    st = ST_EDGE;
                    break;
                end
                if (by_char) begin
                    n = back ? width_before() : width_after();
                    if (n == 0) begin
                        st = ST_INVALID;
                        break;
                    end
                end
                if (erase) begin
                    if (back) gap_start -= n;
                    else gap_end += n;
                    free_space += n;
                    text_length -= n;
                end else if (back) begin
                    for (k = 0; k < n; k++) begin
                        gap_end--;
                        gap_start--;
                        store[gap_end] = store[gap_start];
                    end
                end else begin
                    for (k = 0; k < n; k++) begin
                        store[gap_start] = store[gap_end];
                        gap_start++;
                        gap_end++;
                    end
                end
                done++;
            end
            return done;
        endfunction

        function t_result apply_edit(t_item it);
            t_result r;
            int unsigned done;
            int unsigned idx;
            logic [STAT_W-1:0] st;
            logic [BYTE_W-1:0] rb;
            done = 0;
            st = ST_OK;
            rb = '0;
            if (it.action == ACT_INSERT) begin
                if (free_space <= 1) begin
                    st = ST_FULL;
                end else begin
                    store[gap_start] = it.insert_byte;
                    gap_start++;
                    free_space--;
                    text_length++;
                    done = 1;
                end
            end else if (it.action >= ACT_DEL_BEFORE && it.action <= ACT_DEL_CHAR_AF) begin
                done = step_run(it.action, it.step_count, st);
            end else if (it.action == ACT_READ) begin
                if (it.read_position < text_length) begin
                    // skip the gap for offsets past the cursor
                    idx = (it.read_position < gap_start) ? it.read_position
                                                         : it.read_position + free_space;
                    if (idx < CAP) rb = store[idx];
                    done = 1;
                end else begin
                    st = ST_EDGE;
                end
            end
            r.done_count = CNT_W'(done);
            r.cursor_pos = CNT_W'(gap_start);
            r.text_len = CNT_W'(text_length);
            r.read_byte = rb;
            r.status = st;
            return r;
        endfunction

        function void note_item(t_item it);
            t_result r;
            r = apply_edit(it);
            edit_outcomes.push_back(r);
            status_tally[r.status]++;
            if (text_length > longest_text) longest_text = text_length;
        endfunction

        function void flag(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch on %s of result %0d: expected %0d, got %0d",
                             what, results_checked, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (edit_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result beat: done %0d cursor %0d len %0d",
                             got.done_count, got.cursor_pos, got.text_len);
                return;
            end
            want = edit_outcomes.pop_front();
            flag("done_count", want.done_count, got.done_count);
            flag("cursor_pos", want.cursor_pos, got.cursor_pos);
            flag("text_len", want.text_len, got.text_len);
            flag("read_byte", CNT_W'(want.read_byte), CNT_W'(got.read_byte));
            flag("status", CNT_W'(want.status), CNT_W'(got.status));
            results_checked++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_item i_item = '0;
    logic busy;
    logic o_strobe;
    t_result o_result;

    gap_buffer_shadow shadow = new();
    bit idle_on = 1'b1;
    int unsigned beats_sent = 0;
    logic [BYTE_W-1:0] char_bytes [$];

    gap_buffer_edit_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) shadow.check_result(o_result);
    end

    function automatic t_item edit(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] b,
                                   logic [CNT_W-1:0] cnt, logic [POS_W-1:0] pos);
        t_item it;
        it.action = act;
        it.insert_byte = b;
        it.step_count = cnt;
        it.read_position = pos;
        return it;
    endfunction

    // Queue the bytes of one character: mostly well formed, some stray bytes.
    function automatic void queue_char();
        int unsigned n;
        int unsigned k;
        int unsigned r;
        logic [BYTE_W-1:0] b;
        r = $urandom_range(0, 99);
        b = BYTE_W'($urandom);
        if (r < 80) begin
            n = $urandom_range(1, 4);
            case (n)
                1: b[7] = 1'b0;
                2: b[7:5] = 3'b110;
                3: b[7:4] = 4'b1110;
                default: b[7:3] = 5'b11110;
            endcase
            char_bytes.push_back(b);
            for (k = 1; k < n; k++) begin
                b = BYTE_W'($urandom);
                b[7:6] = 2'b10;
                char_bytes.push_back(b);
            end
        end else if (r < 85) begin
            // run of continuation bytes
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++) begin
                b = BYTE_W'($urandom);
                b[7:6] = 2'b10;
                char_bytes.push_back(b);
            end
        end else begin
            char_bytes.push_back(b);
        end
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return CNT_W'($urandom_range(0, 4));
        if (r < 95) return CNT_W'($urandom_range(5, 40));
        if (r < 98) return COUNT_ALL;
        return CNT_W'($urandom_range(0, CAP));
    endfunction

    function automatic logic [POS_W-1:0] rand_position();
        if (shadow.text_length != 0 && $urandom_range(0, 4) != 0)
            return POS_W'($urandom_range(0, shadow.text_length - 1));
        return POS_W'($urandom);
    endfunction

    function automatic t_item random_edit(int unsigned len_cap);
        t_item it;
        int unsigned r;
        it.action = ACT_READ;
        it.insert_byte = BYTE_W'($urandom);
        it.step_count = rand_count();
        it.read_position = rand_position();
        // finish a started character most of the time
        if (char_bytes.size() != 0 && $urandom_range(0, 9) != 0) r = 0;
        else r = $urandom_range(0, 99);
        if (r < 30) begin
            if (shadow.text_length >= len_cap) begin
                it.action = $urandom_range(0, 1) ? ACT_DEL_BEFORE : ACT_DEL_AFTER;
                it.step_count = CNT_W'($urandom_range(1, 32));
            end else begin
                if (char_bytes.size() == 0) queue_char();
                it.action = ACT_INSERT;
                it.insert_byte = char_bytes.pop_front();
            end
        end else if (r < 40) it.action = ACT_READ;
        else if (r < 47) it.action = ACT_LEFT_BYTES;
        else if (r < 54) it.action = ACT_RIGHT_BYTES;
        else if (r < 64) it.action = ACT_LEFT_CHARS;
        else if (r < 74) it.action = ACT_RIGHT_CHARS;
        else if (r < 79) it.action = ACT_DEL_BEFORE;
        else if (r < 84) it.action = ACT_DEL_AFTER;
        else if (r < 90) it.action = ACT_DEL_CHAR_BF;
        else if (r < 96) it.action = ACT_DEL_CHAR_AF;
        else if (r < 98) it.action = ACT_W'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
        else it.action = ACT_READ;
        return it;
    endfunction

    function automatic t_item fill_edit();
        t_item it;
        int unsigned r;
        it = edit(ACT_INSERT, '0, CNT_W'($urandom_range(0, 4)), rand_position());
        r = $urandom_range(0, 99);
        if (r < 90 || char_bytes.size() != 0) begin
            if (char_bytes.size() == 0) queue_char();
            it.insert_byte = char_bytes.pop_front();
        end else if (r < 94) it.action = ACT_READ;
        else if (r < 96) it.action = ACT_LEFT_BYTES;
        else if (r < 98) it.action = ACT_LEFT_CHARS;
        else it.action = ACT_RIGHT_CHARS;
        return it;
    endfunction

    task automatic send(input t_item it, input bit lower);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        shadow.note_item(it);
        beats_sent++;
        if (lower || (idle_on && $urandom_range(0, 3) == 0)) begin
            start <= 1'b0;
            if (idle_on) repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (shadow.edit_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_mix(input int unsigned items, input int unsigned len_cap);
        int unsigned i;
        for (i = 0; i < items; i++) send(random_edit(len_cap), i == items - 1);
    endtask

    initial begin
        int unsigned n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty text: every walk and read hits the edge
        send(edit(ACT_READ, 8'hFF, '0, '0), 1'b0);
        send(edit(ACT_LEFT_BYTES, '0, 13'd5, '1), 1'b0);
        send(edit(ACT_DEL_AFTER, '0, 13'd3, '0), 1'b0);
        // one character of each length
        send(edit(ACT_INSERT, 8'h41, '0, '0), 1'b0);
        send(edit(ACT_INSERT, 8'hC3, '0, '0), 1'b0);
        send(edit(ACT_INSERT, 8'hA9, '0, '0), 1'b0);
        send(edit(ACT_INSERT, 8'hE2, '0, '0), 1'b0);
        send(edit(ACT_INSERT, 8'h82, '0, '0), 1'b0);
        send(edit(ACT_INSERT, 8'hAC, '0, '0), 1'b0);
        send(edit(ACT_INSERT, 8'hF0, '0, '0), 1'b0);
        send(edit(ACT_INSERT, 8'h9F, '0, '0), 1'b0);
        send(edit(ACT_INSERT, 8'h98, '0, '0), 1'b0);
        send(edit(ACT_INSERT, 8'h80, '0, '0), 1'b0);
        send(edit(ACT_LEFT_CHARS, '0, COUNT_ALL, '0), 1'b0);
        send(edit(ACT_RIGHT_CHARS, '0, 13'd2, '0), 1'b0);
        send(edit(ACT_LEFT_BYTES, '0, '0, '0), 1'b0);
        send(edit(ACT_READ, '0, '1, 12'd3), 1'b0);
        send(edit(ACT_UNKNOWN_HI, '1, '1, '1), 1'b0);
        // four continuation bytes in a row before the cursor
        send(edit(ACT_INSERT, 8'h80, '0, '0), 1'b0);
        send(edit(ACT_INSERT, 8'hBF, '0, '0), 1'b0);
        send(edit(ACT_INSERT, 8'h80, '0, '0), 1'b0);
        send(edit(ACT_LEFT_CHARS, '0, 13'd1, '0), 1'b0);
        send(edit(ACT_DEL_CHAR_AF, '0, 13'd1, '0), 1'b0);
        send(edit(ACT_RIGHT_BYTES, '0, COUNT_ALL, '0), 1'b0);
        send(edit(ACT_DEL_CHAR_BF, '0, COUNT_ALL, '0), 1'b0);
        send(edit(ACT_DEL_BEFORE, '0, COUNT_ALL, '0), 1'b1);
        drain();

        run_mix(600, 200);
        drain();

        // fill to CAP - 1 bytes, the most the store takes, then walk and trim the full store
        while (shadow.text_length < CAP - 1) send(fill_edit(), 1'b0);
        send(edit(ACT_INSERT, 8'h00, '0, '0), 1'b0);
        send(edit(ACT_INSERT, 8'hFF, '1, '1), 1'b0);
        send(edit(ACT_LEFT_BYTES, '0, COUNT_ALL, '0), 1'b0);
        send(edit(ACT_READ, '0, '0, 12'hFFF), 1'b0);
        send(edit(ACT_RIGHT_CHARS, '0, COUNT_ALL, '0), 1'b0);
        send(edit(ACT_READ, '0, '0, rand_position()), 1'b0);
        send(edit(ACT_RIGHT_BYTES, '0, COUNT_ALL, '0), 1'b0);
        send(edit(ACT_LEFT_CHARS, '0, COUNT_ALL, '0), 1'b0);
        send(edit(ACT_READ, '0, '0, rand_position()), 1'b0);
        send(edit(ACT_INSERT, 8'h5A, '0, '0), 1'b0);
        send(edit(ACT_DEL_CHAR_BF, '0, COUNT_ALL, '0), 1'b0);
        send(edit(ACT_DEL_CHAR_AF, '0, COUNT_ALL, '0), 1'b0);
        send(edit(ACT_LEFT_BYTES, '0, 13'd2000, '0), 1'b0);
        send(edit(ACT_READ, '0, '0, rand_position()), 1'b0);
        send(edit(ACT_DEL_AFTER, '0, COUNT_ALL, '0), 1'b0);
        send(edit(ACT_DEL_BEFORE, '0, COUNT_ALL, '0), 1'b1);
        drain();

        run_mix(700, 300);
        drain();

        // closing stretch: sender never idles
        idle_on = 1'b0;
        run_mix(500, 300);

        n = 0;
        while (shadow.edit_outcomes.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (16) @(posedge i_clk);

        $display("summary: %0d edits sent, %0d results checked, longest text %0d bytes",
                 beats_sent, shadow.results_checked, shadow.longest_text);
        $display("summary: ok %0d, edge stops %0d, invalid chars %0d, refused inserts %0d",
                 shadow.status_tally[ST_OK], shadow.status_tally[ST_EDGE],
                 shadow.status_tally[ST_INVALID], shadow.status_tally[ST_FULL]);
        if (shadow.mismatches == 0 && shadow.edit_outcomes.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     shadow.mismatches, shadow.edit_outcomes.size());
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("timeout with %0d results outstanding", shadow.edit_outcomes.size());
        $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
